>>> rtl/lr_expression_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LR expression parser
// Short forms for clocked implications with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LR_EXPRESSION_PARSER_ASSERT_SVH
`define LR_EXPRESSION_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lr_expression_parser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lr_expression_parser: next-cycle check failed");

`endif

>>> rtl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Types, codes and parse tables shared by the LR expression parser modules.
// ----------------------------------------------------------------------------
package lrp_pkg;

    localparam int DEF_STACK_DEPTH = 32;
    localparam int MAX_RESULTS     = 34;
    localparam int STATE_W         = 5;
    localparam int RES_W           = 6;
    localparam int DEPTH_W         = 6;

    // Terminal codes.
    localparam logic [3:0] SYM_PLUS   = 4'd0;
    localparam logic [3:0] SYM_MINUS  = 4'd1;
    localparam logic [3:0] SYM_STAR   = 4'd2;
    localparam logic [3:0] SYM_SLASH  = 4'd3;
    localparam logic [3:0] SYM_ASSIGN = 4'd4;
    localparam logic [3:0] SYM_ID     = 4'd5;
    localparam logic [3:0] SYM_LPAREN = 4'd6;
    localparam logic [3:0] SYM_RPAREN = 4'd7;
    localparam logic [3:0] SYM_SEMI   = 4'd8;
    localparam logic [3:0] SYM_OTHER  = 4'd9;

    // Result action codes.
    localparam logic [2:0] ACT_SHIFT     = 3'd0;
    localparam logic [2:0] ACT_REDUCE    = 3'd1;
    localparam logic [2:0] ACT_ACCEPT    = 3'd2;
    localparam logic [2:0] ACT_ERROR     = 3'd3;
    localparam logic [2:0] ACT_RESTARTED = 3'd4;

    // Action table entry encoding: zero is no entry, small values shift.
    localparam logic [6:0] ENT_NONE = 7'h00;
    localparam logic [6:0] ENT_RED  = 7'h20;
    localparam logic [6:0] ENT_ACC  = 7'h40;

    typedef struct packed {
        logic       kind;
        logic [3:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] rule;
        logic [4:0] new_state;
        logic [5:0] depth;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_GOTO
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic emit_restart;
        logic emit_error;
        logic do_shift;
        logic rd_issue;
        logic do_reduce;
    } lrp_cmd_t;

    typedef struct packed {
        logic restart;
        logic no_entry;
        logic budget_out;
        logic shift;
        logic accept;
        logic full;
        logic underflow;
        logic goto_none;
        logic out_free;
    } lrp_status_t;

    function automatic logic [6:0] act_entry(input logic [4:0] st, input logic [3:0] col);
        logic [6:0] e;
        logic       follow;
        begin
            e      = ENT_NONE;
            follow = col inside {SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH, SYM_ASSIGN,
                                 SYM_RPAREN, SYM_SEMI};
            case (st)
                5'd0, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8, 5'd16:
                begin
                    case (col)
                        SYM_MINUS:  e = 7'd2;
                        SYM_ID:     e = 7'd4;
                        SYM_LPAREN: e = 7'd3;
                        default:    e = ENT_NONE;
                    endcase
                end
                5'd1, 5'd10, 5'd17:
                begin
                    case (col)
                        SYM_PLUS:   e = 7'd5;
                        SYM_MINUS:  e = 7'd6;
                        SYM_STAR:   e = 7'd7;
                        SYM_SLASH:  e = 7'd8;
                        SYM_ASSIGN: e = (st == 5'd1) ? 7'd16 : ENT_NONE;
                        SYM_RPAREN: e = (st == 5'd10) ? 7'd15 : ENT_NONE;
                        SYM_SEMI:   e = (st == 5'd17) ? ENT_ACC : ENT_NONE;
                        default:    e = ENT_NONE;
                    endcase
                end
                5'd11, 5'd12:
                begin
                    if (col == SYM_STAR)
                        e = 7'd7;
                    else if (col == SYM_SLASH)
                        e = 7'd8;
                    else if (follow)
                        e = ENT_RED | ((st == 5'd11) ? 7'd3 : 7'd4);
                    else
                        e = ENT_NONE;
                end
                5'd4:  e = follow ? (ENT_RED | 7'd1) : ENT_NONE;
                5'd9:  e = follow ? (ENT_RED | 7'd2) : ENT_NONE;
                5'd13: e = follow ? (ENT_RED | 7'd5) : ENT_NONE;
                5'd14: e = follow ? (ENT_RED | 7'd6) : ENT_NONE;
                5'd15: e = follow ? (ENT_RED | 7'd7) : ENT_NONE;
                default: e = ENT_NONE;
            endcase
            return e;
        end
    endfunction

    function automatic logic [4:0] goto_state(input logic [4:0] st);
        logic [4:0] g;
        begin
            case (st)
                5'd0:    g = 5'd1;
                5'd2:    g = 5'd9;
                5'd3:    g = 5'd10;
                5'd5:    g = 5'd11;
                5'd6:    g = 5'd12;
                5'd7:    g = 5'd13;
                5'd8:    g = 5'd14;
                5'd16:   g = 5'd17;
                default: g = 5'd0;
            endcase
            return g;
        end
    endfunction

    // Stack entries popped per rule; rule zero is the statement rule.
    function automatic logic [1:0] rule_size(input logic [2:0] rule);
        logic [1:0] s;
        begin
            case (rule)
                3'd1:    s = 2'd1;
                3'd2:    s = 2'd2;
                default: s = 2'd3;
            endcase
            return s;
        end
    endfunction

endpackage

>>> rtl/lrp_ctrl.sv
// ----------------------------------------------------------------------------
// lrp_ctrl
// Parser sequencer: takes a word, then steps action lookups and goto commits.
// ----------------------------------------------------------------------------
module lrp_ctrl
    import lrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tok_valid,
    output logic        tok_ready,
    input  lrp_status_t status,
    output lrp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        tok_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                tok_ready = 1'b1;
                if (tok_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.restart)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_restart = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else if (status.no_entry || status.budget_out)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_error = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (status.shift)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_error = status.full;
                        cmd.do_shift   = !status.full;
                        state_next     = ST_IDLE;
                    end
                end
                else if (status.underflow)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_error = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_GOTO;
                end
            end
            ST_GOTO:
            begin
                if (status.out_free)
                begin
                    if (status.goto_none)
                    begin
                        cmd.emit_error = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.do_reduce = 1'b1;
                        state_next    = status.accept ? ST_IDLE : ST_EVAL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/lrp_dpath.sv
// ----------------------------------------------------------------------------
// lrp_dpath
// State stack memory, table lookups and the result register of the parser.
// ----------------------------------------------------------------------------
module lrp_dpath
    import lrp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    tok,
    input  lrp_cmd_t    cmd,
    output lrp_status_t status,
    output logic        res_valid,
    input  logic        res_ready,
    output out_item_t   res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic                kind_reg;
    logic [3:0]          col_reg;
    logic [STATE_W-1:0]  top_reg;
    logic [CW-1:0]       count_reg;
    logic [RES_W-1:0]    n_reg;
    logic                res_valid_reg;
    out_item_t           res_reg;

    logic [STATE_W-1:0]  stack_mem [STACK_DEPTH];
    logic [STATE_W-1:0]  rdata_reg;
    logic                rd_zero_reg;

    logic [6:0]          entry;
    logic                is_acc;
    logic                is_shift;
    logic [2:0]          rule;
    logic [CW-1:0]       size_ext;
    logic [CW-1:0]       rd_addr;
    logic [CW-1:0]       base;
    logic [STATE_W-1:0]  under;
    logic [STATE_W-1:0]  g;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [STATE_W-1:0]  mem_wdata;
    logic                emit;
    logic [CW-1:0]       depth_src;
    logic [CW+DEPTH_W-1:0] depth_wide;
    out_item_t           res_next;

    assign entry    = act_entry(top_reg, col_reg);
    assign is_acc   = (entry == ENT_ACC);
    assign is_shift = (entry != ENT_NONE) && (entry < ENT_RED);
    assign rule     = is_acc ? 3'd0 : entry[2:0];
    assign size_ext = CW'(rule_size(rule));
    assign rd_addr  = count_reg - CW'(1) - size_ext;
    assign base     = count_reg - size_ext;
    assign under    = rd_zero_reg ? '0 : rdata_reg;
    assign g        = goto_state(under);

    always_comb
    begin
        status.restart    = kind_reg;
        status.no_entry   = (entry == ENT_NONE);
        status.budget_out = (n_reg >= RES_W'(MAX_RESULTS - 1));
        status.shift      = is_shift;
        status.accept     = is_acc;
        status.full       = (count_reg >= CW'(STACK_DEPTH));
        status.underflow  = (size_ext >= count_reg);
        status.goto_none  = (g == '0);
        status.out_free   = !res_valid_reg || res_ready;
    end

    assign mem_we    = cmd.do_shift || cmd.do_reduce;
    assign mem_waddr = cmd.do_shift ? count_reg[AW-1:0] : base[AW-1:0];
    assign mem_wdata = cmd.do_shift ? entry[STATE_W-1:0] : g;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[mem_waddr] <= mem_wdata;
        if (cmd.rd_issue)
        begin
            rdata_reg   <= stack_mem[rd_addr[AW-1:0]];
            rd_zero_reg <= (rd_addr == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= 1'b0;
            col_reg   <= SYM_PLUS;
            top_reg   <= '0;
            count_reg <= CW'(1);
            n_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg <= tok.kind;
                col_reg  <= (tok.symbol > SYM_OTHER) ? SYM_OTHER : tok.symbol;
                n_reg    <= '0;
            end
            if (cmd.emit_restart)
            begin
                top_reg   <= '0;
                count_reg <= CW'(1);
            end
            if (cmd.do_shift)
            begin
                top_reg   <= entry[STATE_W-1:0];
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.do_reduce)
            begin
                top_reg   <= g;
                count_reg <= base + CW'(1);
                n_reg     <= n_reg + RES_W'(1);
            end
        end
    end

    assign emit = cmd.emit_restart || cmd.emit_error || cmd.do_shift || cmd.do_reduce;

    always_comb
    begin
        if (cmd.emit_restart)
            depth_src = CW'(1);
        else if (cmd.do_shift)
            depth_src = count_reg + CW'(1);
        else if (cmd.do_reduce)
            depth_src = base + CW'(1);
        else
            depth_src = count_reg;
        depth_wide = {{DEPTH_W{1'b0}}, depth_src};

        res_next.action    = ACT_ERROR;
        res_next.rule      = 3'd0;
        res_next.new_state = top_reg;
        res_next.depth     = depth_wide[DEPTH_W-1:0];
        res_next.last      = 1'b1;
        if (cmd.emit_restart)
        begin
            res_next.action    = ACT_RESTARTED;
            res_next.new_state = '0;
        end
        else if (cmd.do_shift)
        begin
            res_next.action    = ACT_SHIFT;
            res_next.new_state = entry[STATE_W-1:0];
        end
        else if (cmd.do_reduce)
        begin
            res_next.action    = is_acc ? ACT_ACCEPT : ACT_REDUCE;
            res_next.rule      = rule;
            res_next.new_state = g;
            res_next.last      = is_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (emit)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/lr_expression_parser.sv
// ----------------------------------------------------------------------------
// lr_expression_parser
// Table-driven shift-reduce parser for statements of the form E = E ;.
//
// The tok channel carries one word per item: a token symbol, or a restart
// request that empties the stack. The res channel carries one word per parser
// action (shift, reduce, accept, error, restarted); last marks the final word
// of an item. A token causes a chain of zero or more reductions followed by a
// shift, an accept or an error.
// Timing: a token is registered when taken and looked up in the next cycle.
// A shift, an error or a restart is emitted once the result register is
// free. Each reduction steps through the action lookup, then the stack memory
// read under the popped symbols and the goto commit.
// tok_ready is high only while no item is in progress.
// Each result sits in an output register; a stalled receiver holds the
// sequencer in place until the register frees, and no result is dropped.
// Reset leaves a stack holding state 0 with depth 1; no clearing pass is run.
// ----------------------------------------------------------------------------
module lr_expression_parser
    import lrp_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tok_valid,
    output logic      tok_ready,
    input  in_item_t  tok,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res
);

    lrp_cmd_t    cmd;
    lrp_status_t status;

    lrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lrp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

`include "lr_expression_parser_assert.svh"

    `LRP_ASSERT_SAME(a_one_action, clk, rst_n, 1'b1, $onehot0({cmd.emit_restart, cmd.emit_error, cmd.do_shift, cmd.do_reduce}))
    `LRP_ASSERT_SAME(a_not_last_is_reduce, clk, rst_n, res_valid && !res.last, res.action == ACT_REDUCE)
    `LRP_ASSERT_SAME(a_restart_result, clk, rst_n, res_valid && (res.action == ACT_RESTARTED), (res.new_state == '0) && (res.depth == 6'd1))
    `LRP_ASSERT_NEXT(a_one_item, clk, rst_n, tok_valid && tok_ready, !tok_ready)

endmodule

>>> tb/sv/tb_lr_expression_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lr_expression_parser
// Self-checking testbench for the shift-reduce expression parser.
//
// Token and restart words go in on the tok channel. A parse-table model in
// this file keeps its own state stack and predicts every action word on the
// res channel. Directed tests cover all operators and rules, error cases and
// the stack limits. Random statements with some corrupted tokens then run
// under four sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_lr_expression_parser;
    import lrp_pkg::*;

    localparam int  STACK_LIMIT   = DEF_STACK_DEPTH;
    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  SETTLE_CYCLES = 80;
    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      tok_valid = 1'b0;
    logic      tok_ready;
    in_item_t  tok = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    out_item_t res;

    logic [4:0]  parse_stack [0:STACK_LIMIT-1];
    int          stack_fill;
    out_item_t   expected_actions [$];
    logic [3:0]  token_seq [$];

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int words_sent;
    int results_checked;
    int mismatch_count;
    int deepest_stack;
    int action_tally [0:7];

    lr_expression_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_actions.size());
        $display("** lr_expression_parser: FAILED **");
        $finish;
    end

    // Action table: zero is no entry, below ENT_RED a shift target, else a
    // reduction of the rule in the low bits, or the accept entry.
    function automatic logic [6:0] parse_entry(input logic [4:0] st, input logic [3:0] col);
        logic       may_follow;
        logic [6:0] e;
        begin
            may_follow = (col <= SYM_ASSIGN) || (col == SYM_RPAREN) || (col == SYM_SEMI);
            e = ENT_NONE;
            case (st)
                5'd0, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8, 5'd16:
                begin
                    if (col == SYM_MINUS)
                        e = 7'd2;
                    else if (col == SYM_ID)
                        e = 7'd4;
                    else if (col == SYM_LPAREN)
                        e = 7'd3;
                end
                5'd1, 5'd10, 5'd17:
                begin
                    case (col)
                        SYM_PLUS:   e = 7'd5;
                        SYM_MINUS:  e = 7'd6;
                        SYM_STAR:   e = 7'd7;
                        SYM_SLASH:  e = 7'd8;
                        SYM_ASSIGN: if (st == 5'd1) e = 7'd16;
                        SYM_RPAREN: if (st == 5'd10) e = 7'd15;
                        SYM_SEMI:   if (st == 5'd17) e = ENT_ACC;
                        default:    e = ENT_NONE;
                    endcase
                end
                5'd11, 5'd12:
                begin
                    if (col == SYM_STAR)
                        e = 7'd7;
                    else if (col == SYM_SLASH)
                        e = 7'd8;
                    else if (may_follow)
                        e = ENT_RED | ((st == 5'd11) ? 7'd3 : 7'd4);
                end
                5'd4:  if (may_follow) e = ENT_RED | 7'd1;
                5'd9:  if (may_follow) e = ENT_RED | 7'd2;
                5'd13: if (may_follow) e = ENT_RED | 7'd5;
                5'd14: if (may_follow) e = ENT_RED | 7'd6;
                5'd15: if (may_follow) e = ENT_RED | 7'd7;
                default: e = ENT_NONE;
            endcase
            return e;
        end
    endfunction

    function automatic logic [4:0] goto_on_expr(input logic [4:0] st);
        begin
            case (st)
                5'd0:    return 5'd1;
                5'd2:    return 5'd9;
                5'd3:    return 5'd10;
                5'd5:    return 5'd11;
                5'd6:    return 5'd12;
                5'd7:    return 5'd13;
                5'd8:    return 5'd14;
                5'd16:   return 5'd17;
                default: return 5'd0;
            endcase
        end
    endfunction

    function automatic void expect_word(input out_item_t r);
        begin
            expected_actions = {expected_actions, r};
        end
    endfunction

    function automatic void add_token(input logic [3:0] sym);
        begin
            token_seq = {token_seq, sym};
        end
    endfunction

    task automatic clear_parse_stack();
        begin
            foreach (parse_stack[i])
                parse_stack[i] = 5'd0;
            stack_fill = 1;
        end
    endtask

    task automatic predict_actions(input in_item_t w);
        out_item_t  r;
        logic [3:0] col;
        logic [4:0] top;
        logic [4:0] under;
        logic [4:0] dest;
        logic [6:0] ent;
        logic [2:0] rule;
        int         pops;
        int         n;
        bit         done;
        begin
            if (w.kind == KIND_RESTART)
            begin
                clear_parse_stack();
                r.action    = ACT_RESTARTED;
                r.rule      = 3'd0;
                r.new_state = 5'd0;
                r.depth     = 6'd1;
                r.last      = 1'b1;
                expect_word(r);
                return;
            end
            col  = (w.symbol > SYM_OTHER) ? SYM_OTHER : w.symbol;
            n    = 0;
            done = 1'b0;
            while (!done)
            begin
                top         = parse_stack[stack_fill - 1];
                ent         = parse_entry(top, col);
                r.action    = ACT_ERROR;
                r.rule      = 3'd0;
                r.new_state = top;
                r.depth     = 6'(stack_fill);
                r.last      = 1'b1;
                done        = 1'b1;
                if (ent == ENT_NONE || n >= MAX_RESULTS - 1)
                begin
                    r.action = ACT_ERROR;
                end
                else if (ent < ENT_RED)
                begin
                    if (stack_fill < STACK_LIMIT)
                    begin
                        parse_stack[stack_fill] = ent[4:0];
                        stack_fill++;
                        r.action    = ACT_SHIFT;
                        r.new_state = ent[4:0];
                        r.depth     = 6'(stack_fill);
                    end
                end
                else
                begin
                    rule = (ent == ENT_ACC) ? 3'd0 : ent[2:0];
                    pops = (rule == 3'd1) ? 1 : ((rule == 3'd2) ? 2 : 3);
                    if (pops < stack_fill)
                    begin
                        under = parse_stack[stack_fill - 1 - pops];
                        dest  = goto_on_expr(under);
                        if (dest != 5'd0)
                        begin
                            stack_fill -= pops;
                            parse_stack[stack_fill] = dest;
                            stack_fill++;
                            r.new_state = dest;
                            r.depth     = 6'(stack_fill);
                            if (ent == ENT_ACC)
                                r.action = ACT_ACCEPT;
                            else
                            begin
                                r.action = ACT_REDUCE;
                                r.rule   = rule;
                                r.last   = 1'b0;
                                done     = 1'b0;
                            end
                        end
                    end
                end
                if (stack_fill > deepest_stack)
                    deepest_stack = stack_fill;
                expect_word(r);
                n++;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH at cycle %0d, result %0d: %s", cycle_count, results_checked, msg);
            mismatch_count++;
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        begin
            if (got != want)
                report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        begin
            results_checked++;
            action_tally[got.action]++;
            if (expected_actions.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word: action %0d state %0d depth %0d",
                                          got.action, got.new_state, got.depth));
                return;
            end
            want = expected_actions.pop_front();
            check_field("action", int'(got.action), int'(want.action));
            check_field("rule", int'(got.rule), int'(want.rule));
            check_field("new_state", int'(got.new_state), int'(want.new_state));
            check_field("depth", int'(got.depth), int'(want.depth));
            check_field("last", int'(got.last), int'(want.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            check_result(res);
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high after a word is taken; the next call replaces the
    // payload in the same time step unless a gap or a drain lowers it first.
    task automatic send_word(input logic kind, input logic [3:0] sym);
        in_item_t w;
        begin
            w.kind   = kind;
            w.symbol = sym;
            tok_valid <= 1'b1;
            tok       <= w;
            do
                @(posedge clk);
            while (!tok_ready);
            predict_actions(w);
            words_sent++;
            while ($urandom_range(99) < send_idle_pct)
            begin
                tok_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_token(input logic [3:0] sym);
        begin
            send_word(KIND_TOKEN, sym);
        end
    endtask

    task automatic wait_results_done();
        begin
            tok_valid <= 1'b0;
            while (expected_actions.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic test_all_operators();
        begin
            send_token(SYM_MINUS);
            send_token(SYM_LPAREN);
            send_token(SYM_ID);
            send_token(SYM_PLUS);
            send_token(SYM_ID);
            send_token(SYM_STAR);
            send_token(SYM_ID);
            send_token(SYM_SLASH);
            send_token(SYM_ID);
            send_token(SYM_MINUS);
            send_token(SYM_ID);
            send_token(SYM_RPAREN);
            send_token(SYM_ASSIGN);
            send_token(SYM_ID);
            send_token(SYM_SEMI);
            send_token(SYM_SEMI);
            send_word(KIND_RESTART, SYM_ID);
        end
    endtask

    task automatic test_error_cases();
        begin
            send_token(SYM_OTHER);
            send_token(4'd15);
            send_token(4'd12);
            send_token(SYM_RPAREN);
            send_token(SYM_ASSIGN);
            send_token(SYM_ID);
            send_token(SYM_ID);
            send_token(SYM_SEMI);
            send_word(KIND_RESTART, 4'd15);
        end
    endtask

    task automatic test_stack_limits();
        logic [3:0] sym;
        begin
            for (int i = 0; i < STACK_LIMIT + 1; i++)
            begin
                sym = $urandom_range(1) ? SYM_MINUS : SYM_LPAREN;
                send_token(sym);
            end
            send_token(SYM_ID);
            send_word(KIND_RESTART, SYM_SEMI);
            // Fill the stack after "id =" with unary minus, then let ';'
            // unwind the whole chain in one go.
            send_token(SYM_ID);
            send_token(SYM_ASSIGN);
            for (int i = 0; i < STACK_LIMIT - 4; i++)
                send_token(SYM_MINUS);
            send_token(SYM_ID);
            send_token(SYM_SEMI);
            send_word(KIND_RESTART, 4'd0);
        end
    endtask

    function automatic void add_expr(input int budget);
        int pick;
        begin
            pick = (budget <= 0) ? 0 : $urandom_range(9);
            if (pick < 3)
                add_token(SYM_ID);
            else if (pick == 3)
            begin
                add_token(SYM_MINUS);
                add_expr(budget - 1);
            end
            else if (pick < 6)
            begin
                add_token(SYM_LPAREN);
                add_expr(budget - 1);
                add_token(SYM_RPAREN);
            end
            else
            begin
                add_expr(budget - 1);
                add_token(4'($urandom_range(SYM_SLASH)));
                add_expr(budget - 1);
            end
        end
    endfunction

    task automatic test_random_statements(input int word_quota);
        int stop_at;
        int pick;
        int cut;
        begin
            stop_at = words_sent + word_quota;
            while (words_sent < stop_at)
            begin
                token_seq.delete();
                pick = $urandom_range(99);
                if (pick < 6)
                    wait_results_done();
                if (pick < 88)
                    send_word(KIND_RESTART, 4'($urandom_range(15)));
                else if (pick < 94)
                    send_word(1'($urandom_range(1)), 4'($urandom_range(15)));
                add_expr(($urandom_range(9) == 0) ? 7 : $urandom_range(3));
                add_token(SYM_ASSIGN);
                add_expr($urandom_range(3));
                add_token(SYM_SEMI);
                pick = $urandom_range(99);
                if (pick < 12)
                    token_seq[$urandom_range(token_seq.size() - 1)] = 4'($urandom_range(15));
                else if (pick < 20)
                begin
                    cut = $urandom_range(token_seq.size() - 1);
                    token_seq = token_seq[0:cut];
                end
                else if (pick < 26)
                    token_seq.insert($urandom_range(token_seq.size()), 4'($urandom_range(15)));
                foreach (token_seq[i])
                    send_token(token_seq[i]);
            end
        end
    endtask

    initial
    begin
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        words_sent      = 0;
        deepest_stack   = 1;
        clear_parse_stack();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_all_operators();
        test_error_cases();
        test_stack_limits();
        wait_results_done();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_statements(80);
        wait_results_done();

        send_idle_pct  = 74;
        recv_stall_pct = 0;
        test_random_statements(80);
        wait_results_done();

        send_idle_pct  = 0;
        recv_stall_pct = 74;
        test_random_statements(80);
        wait_results_done();

        send_idle_pct  = 31;
        recv_stall_pct = 31;
        test_random_statements(80);
        wait_results_done();

        $display("Sent %0d words, checked %0d results: %0d shifts, %0d reductions, %0d accepts,",
                 words_sent, results_checked, action_tally[ACT_SHIFT],
                 action_tally[ACT_REDUCE], action_tally[ACT_ACCEPT]);
        $display("%0d errors and %0d restarts; deepest stack %0d entries, %0d mismatches.",
                 action_tally[ACT_ERROR], action_tally[ACT_RESTARTED], deepest_stack,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("** lr_expression_parser: PASSED **");
        else
            $display("** lr_expression_parser: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/lrp_pkg.sv
rtl/lrp_ctrl.sv
rtl/lrp_dpath.sv
rtl/lr_expression_parser.sv
tb/sv/tb_lr_expression_parser.sv
